// ----- hw/rtl/qdal_pkg.sv -----
// qdal_pkg: shared types, register map and constants of the quadrature decoder
// with acceleration and limits; no dependencies
`default_nettype none

package qdal_pkg;

   localparam int unsigned REG_ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_ENABLE = 3'd0,
      REG_CPD    = 3'd1,
      REG_MIN    = 3'd2,
      REG_MAX    = 3'd3,
      REG_WRAP   = 3'd4,
      REG_COEF   = 3'd5
   } qdal_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRE_DIV,
      ST_MUL,
      ST_STEP,
      ST_ACCEL,
      ST_LIM_HI,
      ST_LIM_LO,
      ST_POST_DIV,
      ST_OUT
   } qdal_state_type;

   typedef struct packed {
      logic start;
      logic half;
   } qdal_div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } qdal_div_stat_type;

   localparam logic [1:0] STEP_NONE = 2'b00;
   localparam logic [1:0] STEP_FWD  = 2'b01;
   localparam logic [1:0] STEP_REV  = 2'b11;

   localparam logic [31:0] ACCEL_CUTOFF_MS = 32'd200;
   localparam logic [31:0] ACCEL_MIN_MS    = 32'd4;

   localparam logic [31:0] DET_POS_LIMIT = 32'd8388607;
   localparam logic [31:0] DET_NEG_LIMIT = 32'd8388608;
   localparam logic [23:0] DET_MAX       = 24'h7FFFFF;
   localparam logic [23:0] DET_MIN       = 24'h800000;

   localparam logic [2:0] MUL_LAST = 3'd7;

   // quadrature step from {previous ab, current ab}
   function automatic logic [1:0] step_decode(input logic [3:0] idx);
      logic [1:0] s;
      case (idx)
         4'd1, 4'd7, 4'd8, 4'd14:  s = STEP_REV;
         4'd2, 4'd4, 4'd11, 4'd13: s = STEP_FWD;
         default:                  s = STEP_NONE;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/qdal_div.sv -----
// qdal_div: radix-2 restoring divider, one quotient bit per cycle, 32 or 16 steps
// depends on qdal_pkg
`default_nettype none

module qdal_div import qdal_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire qdal_div_ctl_type  ctl,
   input  wire logic [31:0]       dividend,
   input  wire logic [7:0]        divisor,
   output qdal_div_stat_type      stat,
   output logic [31:0]            quotient,
   output logic [7:0]             remainder
);

   localparam logic [5:0] DIV_STEPS      = 6'd32;
   localparam logic [5:0] DIV_HALF_STEPS = 6'd16;

   logic [5:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [31:0] q_ff, q_in;
   logic [7:0]  r_ff, r_in;
   logic [7:0]  d_ff, d_in;
   logic [8:0]  trial;
   logic [8:0]  diff;
   logic        fits;

   always_comb begin
      trial   = {r_ff, q_ff[31]};
      diff    = trial - {1'b0, d_ff};
      fits    = trial >= {1'b0, d_ff};
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      if (cnt_ff != 6'd0) begin
         q_in    = {q_ff[30:0], fits};
         r_in    = fits ? diff[7:0] : trial[7:0];
         cnt_in  = cnt_ff - 6'd1;
         done_in = (cnt_ff == 6'd1);
      end else if (ctl.start) begin
         q_in   = ctl.half ? {dividend[15:0], 16'h0000} : dividend;
         r_in   = 8'h00;
         d_in   = divisor;
         cnt_in = ctl.half ? DIV_HALF_STEPS : DIV_STEPS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 6'd0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign stat.busy = (cnt_ff != 6'd0);
   assign stat.done = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/quadrature_decoder_accel_limits_unit.sv -----
// quadrature_decoder_accel_limits_unit: top level, register file, control sequencer,
// shift-add limit scaling and result register; depends on qdal_pkg and qdal_div
`default_nettype none

// One transaction is processed at a time; the next request is taken while the
// previous response still waits in the output register. A pin sample that
// produces no step, or is ignored, skips the scaling and the limit checks. A
// sample that moves the count runs through the bit-serial scaling of the limits
// (one bit of counts_per_detent per cycle), the step and limit checks and the
// detent division, which yields one quotient bit per cycle. Acceleration adds a
// 16-bit division by the elapsed time. A preset runs through the same scaling,
// limit checks and division. After counts_per_detent is rewritten, the first
// transaction first rebuilds the cached detent value. All register writes go
// through the APB port and complete without wait states.
module quadrature_decoder_accel_limits_unit import qdal_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_opcode,
   input  wire logic                  req_a_level,
   input  wire logic                  req_b_level,
   input  wire logic [31:0]           req_time_ms,
   input  wire logic signed [23:0]    req_preset_detents,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic signed [31:0]         rsp_position_raw,
   output logic signed [23:0]         rsp_position_detents,
   output logic signed [1:0]          rsp_step_dir,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [REG_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   qdal_state_type state_ff, state_in;

   logic        enable_ff, enable_in;
   logic [7:0]  cpd_ff, cpd_in;
   logic [23:0] min_ff, min_in;
   logic [23:0] max_ff, max_in;
   logic        wrap_ff, wrap_in;
   logic [15:0] coef_ff, coef_in;

   logic [1:0]  prev_ab_ff, prev_ab_in;
   logic [31:0] raw_ff, raw_in;
   logic [31:0] last_time_ff, last_time_in;
   logic [1:0]  last_dir_ff, last_dir_in;
   logic [23:0] det_ff, det_in;
   logic [7:0]  rem_ff, rem_in;
   logic        quo_valid_ff, quo_valid_in;
   logic        launch_ff, launch_in;
   logic [2:0]  mul_cnt_ff, mul_cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        op_ff, op_in;
   logic [31:0] time_ff, time_in;
   logic [1:0]  step_ff, step_in;
   logic [33:0] v_ff, v_in;
   logic [7:0]  dt_ff, dt_in;
   logic [7:0]  mult_ff, mult_in;
   logic [31:0] mc_p_ff, mc_p_in;
   logic [31:0] mc_lo_ff, mc_lo_in;
   logic [31:0] mc_hi_ff, mc_hi_in;
   logic [31:0] acc_p_ff, acc_p_in;
   logic [31:0] acc_lo_ff, acc_lo_in;
   logic [31:0] acc_hi_ff, acc_hi_in;
   logic [31:0] rsp_raw_ff, rsp_raw_in;
   logic [23:0] rsp_det_ff, rsp_det_in;
   logic [1:0]  rsp_step_ff, rsp_step_in;

   logic              csr_write;
   qdal_reg_type      csr_reg;
   logic [7:0]        c_eff;
   logic [7:0]        c_less;
   logic [1:0]        cur_ab;
   logic [1:0]        dec_step;
   logic              raw_neg;
   logic              raw_pos;
   logic [31:0]       abs_raw;
   logic [31:0]       elapsed;
   logic              detent_change;
   logic [33:0]       hi_ext;
   logic [33:0]       lo_ext;
   logic [33:0]       v_sat;
   logic [23:0]       det_sat;

   qdal_div_ctl_type  div_ctl;
   qdal_div_stat_type div_stat;
   logic [31:0]       div_dividend;
   logic [7:0]        div_divisor;
   logic [31:0]       div_quo;
   logic [7:0]        div_rem;

   qdal_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // register file
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_reg    = qdal_reg_type'(csr_paddr[REG_ADDR_W-1:2]);
   assign csr_pready = 1'b1;

   always_comb begin
      enable_in = enable_ff;
      cpd_in    = cpd_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      wrap_in   = wrap_ff;
      coef_in   = coef_ff;
      if (csr_write) begin
         case (csr_reg)
            REG_ENABLE: enable_in = csr_pwdata[0];
            REG_CPD:    cpd_in    = csr_pwdata[7:0];
            REG_MIN:    min_in    = csr_pwdata[23:0];
            REG_MAX:    max_in    = csr_pwdata[23:0];
            REG_WRAP:   wrap_in   = csr_pwdata[0];
            REG_COEF:   coef_in   = csr_pwdata[15:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_ENABLE: csr_prdata = {31'h0, enable_ff};
         REG_CPD:    csr_prdata = {24'h0, cpd_ff};
         REG_MIN:    csr_prdata = {{8{min_ff[23]}}, min_ff};
         REG_MAX:    csr_prdata = {{8{max_ff[23]}}, max_ff};
         REG_WRAP:   csr_prdata = {31'h0, wrap_ff};
         REG_COEF:   csr_prdata = {16'h0, coef_ff};
         default:    csr_prdata = 32'h0;
      endcase
   end

   // datapath helpers
   assign c_eff    = (cpd_ff == 8'd0) ? 8'd1 : cpd_ff;
   assign c_less   = c_eff - 8'd1;
   assign cur_ab   = {req_b_level, req_a_level};
   assign dec_step = step_decode({prev_ab_ff, cur_ab});
   assign raw_neg  = raw_ff[31];
   assign raw_pos  = !raw_ff[31] && (raw_ff != 32'h0);
   assign abs_raw  = raw_neg ? (32'h0 - raw_ff) : raw_ff;
   assign elapsed  = time_ff - last_time_ff;
   assign hi_ext   = {{2{acc_hi_ff[31]}}, acc_hi_ff};
   assign lo_ext   = {{2{acc_lo_ff[31]}}, acc_lo_ff};
   assign v_sat    = ($signed(v_ff) < $signed(lo_ext)) ? (wrap_ff ? hi_ext : lo_ext) : v_ff;

   always_comb begin
      if (step_ff == STEP_FWD) begin
         detent_change = raw_neg ? (rem_ff == 8'd0) : (rem_ff == c_less);
      end else begin
         detent_change = raw_pos ? (rem_ff == 8'd0) : (rem_ff == c_less);
      end
   end

   always_comb begin
      if (!raw_neg) begin
         det_sat = (div_quo > DET_POS_LIMIT) ? DET_MAX : div_quo[23:0];
      end else begin
         det_sat = (div_quo > DET_NEG_LIMIT) ? DET_MIN : (24'h0 - div_quo[23:0]);
      end
   end

   assign div_dividend = (state_ff == ST_ACCEL) ? {16'h0, coef_ff} : abs_raw;
   assign div_divisor  = (state_ff == ST_ACCEL) ? dt_ff : c_eff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      prev_ab_in   = prev_ab_ff;
      raw_in       = raw_ff;
      last_time_in = last_time_ff;
      last_dir_in  = last_dir_ff;
      det_in       = det_ff;
      rem_in       = rem_ff;
      quo_valid_in = quo_valid_ff;
      launch_in    = launch_ff;
      mul_cnt_in   = mul_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      op_in        = op_ff;
      time_in      = time_ff;
      step_in      = step_ff;
      v_in         = v_ff;
      dt_in        = dt_ff;
      mult_in      = mult_ff;
      mc_p_in      = mc_p_ff;
      mc_lo_in     = mc_lo_ff;
      mc_hi_in     = mc_hi_ff;
      acc_p_in     = acc_p_ff;
      acc_lo_in    = acc_lo_ff;
      acc_hi_in    = acc_hi_ff;
      rsp_raw_in   = rsp_raw_ff;
      rsp_det_in   = rsp_det_ff;
      rsp_step_in  = rsp_step_ff;
      div_ctl      = '0;
      req_ready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            mul_cnt_in = 3'd0;
            mult_in    = c_eff;
            mc_lo_in   = {{8{min_ff[23]}}, min_ff};
            mc_hi_in   = {{8{max_ff[23]}}, max_ff};
            acc_p_in   = 32'h0;
            acc_lo_in  = 32'h0;
            acc_hi_in  = 32'h0;
            if (req_valid) begin
               op_in   = req_opcode;
               time_in = req_time_ms;
               mc_p_in = {{8{req_preset_detents[23]}}, req_preset_detents};
               step_in = STEP_NONE;
               if (req_opcode) begin
                  state_in = ST_MUL;
               end else if (enable_ff) begin
                  prev_ab_in = cur_ab;
                  step_in    = dec_step;
                  if (dec_step != STEP_NONE) begin
                     state_in = quo_valid_ff ? ST_MUL : ST_PRE_DIV;
                  end else begin
                     state_in = quo_valid_ff ? ST_OUT : ST_POST_DIV;
                  end
               end else begin
                  state_in = quo_valid_ff ? ST_OUT : ST_POST_DIV;
               end
            end
         end

         ST_PRE_DIV, ST_POST_DIV: begin
            div_ctl.start = !launch_ff;
            launch_in     = 1'b1;
            if (launch_ff && div_stat.done) begin
               launch_in    = 1'b0;
               det_in       = det_sat;
               rem_in       = div_rem;
               quo_valid_in = 1'b1;
               state_in     = (state_ff == ST_PRE_DIV) ? ST_MUL : ST_OUT;
            end
         end

         ST_MUL: begin
            mul_cnt_in = mul_cnt_ff + 3'd1;
            mult_in    = {1'b0, mult_ff[7:1]};
            mc_p_in    = {mc_p_ff[30:0], 1'b0};
            mc_lo_in   = {mc_lo_ff[30:0], 1'b0};
            mc_hi_in   = {mc_hi_ff[30:0], 1'b0};
            if (mult_ff[0]) begin
               acc_p_in  = acc_p_ff + mc_p_ff;
               acc_lo_in = acc_lo_ff + mc_lo_ff;
               acc_hi_in = acc_hi_ff + mc_hi_ff;
            end
            if (mul_cnt_ff == MUL_LAST) begin
               state_in = ST_STEP;
            end
         end

         ST_STEP: begin
            state_in = ST_LIM_HI;
            if (op_ff) begin
               v_in = {{2{acc_p_ff[31]}}, acc_p_ff};
            end else begin
               v_in = {{2{raw_ff[31]}}, raw_ff} + {{32{step_ff[1]}}, step_ff};
               if (detent_change && (coef_ff > 16'd1)) begin
                  last_time_in = time_ff;
                  last_dir_in  = step_ff;
                  if ((step_ff == last_dir_ff) && (elapsed < ACCEL_CUTOFF_MS)) begin
                     dt_in    = (elapsed < ACCEL_MIN_MS) ? ACCEL_MIN_MS[7:0] : elapsed[7:0];
                     state_in = ST_ACCEL;
                  end
               end
            end
         end

         ST_ACCEL: begin
            div_ctl.start = !launch_ff;
            div_ctl.half  = 1'b1;
            launch_in     = 1'b1;
            if (launch_ff && div_stat.done) begin
               launch_in = 1'b0;
               if (step_ff == STEP_FWD) begin
                  v_in = v_ff + {18'h0, div_quo[15:0]};
               end else begin
                  v_in = v_ff - {18'h0, div_quo[15:0]};
               end
               state_in = ST_LIM_HI;
            end
         end

         ST_LIM_HI: begin
            if ($signed(v_ff) > $signed(hi_ext)) begin
               v_in = wrap_ff ? lo_ext : hi_ext;
            end
            state_in = ST_LIM_LO;
         end

         ST_LIM_LO: begin
            raw_in       = v_sat[31:0];
            quo_valid_in = 1'b0;
            state_in     = ST_POST_DIV;
         end

         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_raw_in   = raw_ff;
               rsp_det_in   = det_ff;
               rsp_step_in  = step_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write && (csr_reg == REG_CPD)) begin
         quo_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b1;
         cpd_ff       <= 8'd1;
         min_ff       <= 24'h800000;
         max_ff       <= 24'h7FFFFF;
         wrap_ff      <= 1'b0;
         coef_ff      <= 16'h0;
         prev_ab_ff   <= 2'b00;
         raw_ff       <= 32'h0;
         last_time_ff <= 32'h0;
         last_dir_ff  <= STEP_NONE;
         det_ff       <= 24'h0;
         rem_ff       <= 8'h0;
         quo_valid_ff <= 1'b1;
         launch_ff    <= 1'b0;
         mul_cnt_ff   <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         cpd_ff       <= cpd_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         wrap_ff      <= wrap_in;
         coef_ff      <= coef_in;
         prev_ab_ff   <= prev_ab_in;
         raw_ff       <= raw_in;
         last_time_ff <= last_time_in;
         last_dir_ff  <= last_dir_in;
         det_ff       <= det_in;
         rem_ff       <= rem_in;
         quo_valid_ff <= quo_valid_in;
         launch_ff    <= launch_in;
         mul_cnt_ff   <= mul_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      time_ff     <= time_in;
      step_ff     <= step_in;
      v_ff        <= v_in;
      dt_ff       <= dt_in;
      mult_ff     <= mult_in;
      mc_p_ff     <= mc_p_in;
      mc_lo_ff    <= mc_lo_in;
      mc_hi_ff    <= mc_hi_in;
      acc_p_ff    <= acc_p_in;
      acc_lo_ff   <= acc_lo_in;
      acc_hi_ff   <= acc_hi_in;
      rsp_raw_ff  <= rsp_raw_in;
      rsp_det_ff  <= rsp_det_in;
      rsp_step_ff <= rsp_step_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_position_raw     = rsp_raw_ff;
   assign rsp_position_detents = rsp_det_ff;
   assign rsp_step_dir         = rsp_step_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/qdal_checker.sv -----
// qdal_checker: port-level assertions for the quadrature decoder top level
// bound to quadrature_decoder_accel_limits_unit; no package dependency
`default_nettype none

module qdal_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_position_raw,
   input wire logic [23:0] rsp_position_detents,
   input wire logic [1:0]  rsp_step_dir
);

   // stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position_raw)
         && $stable(rsp_position_detents) && $stable(rsp_step_dir))
      else $error("response changed while stalled");

   // one transaction in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

   a_step_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_step_dir != 2'b10)
      else $error("illegal step code");

   a_zero_detent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_position_raw == 32'h0) |-> rsp_position_detents == 24'h0)
      else $error("nonzero detents at zero count");

endmodule

bind quadrature_decoder_accel_limits_unit qdal_checker u_qdal_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_position_raw     (rsp_position_raw),
   .rsp_position_detents (rsp_position_detents),
   .rsp_step_dir         (rsp_step_dir)
);

`default_nettype wire
